>>> hdl/sgcpm_pkg.sv
// Shared types, widths and constants for the smoothed gain, clip and peak meter.
// Used by every module in hdl/; no dependencies.
package sgcpm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 20;
    localparam int GAIN_BITS      = 31;
    localparam int COEFF_BITS     = 16;
    localparam int THR_BITS       = 21;
    localparam int METER_BITS     = SAMPLE_BITS;
    localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ADDR_BITS      = 4;
    localparam int DATA_BITS      = 32;

    localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_MIN = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam longint CLIP_HI = SAT_MAX * (longint'(1) << GAIN_FRAC_BITS);
    localparam longint CLIP_LO = SAT_MIN * (longint'(1) << GAIN_FRAC_BITS);

    localparam logic [COEFF_BITS-1:0] COEFF_RST  = COEFF_BITS'(22763);
    localparam logic [THR_BITS-1:0]   THR_RST    = THR_BITS'(105);
    localparam logic [COEFF_BITS-1:0] DECAY_RST  = COEFF_BITS'(62259);
    localparam logic [GAIN_BITS-1:0]  GAIN_UNITY = GAIN_BITS'(longint'(1) << GAIN_FRAC_BITS);

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_COEFF = 2'd0;
    localparam t_reg_idx REG_THR   = 2'd1;
    localparam t_reg_idx REG_DECAY = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first_of_buffer;
        logic                          last_of_buffer;
        logic [GAIN_BITS-1:0]          target_gain;
        logic                          clear_clip;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          sample_clipped;
        logic                          clip_seen;
        logic [METER_BITS-1:0]         meter_level;
        logic [GAIN_BITS-1:0]          gain_now;
    } t_out_word;

    // after the gain stage
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic                          clear;
        logic [GAIN_BITS-1:0]          gain;
    } t_gain_item;

    // after the multiplier
    typedef struct packed {
        logic signed [PROD_BITS-1:0] prod;
        logic                        last;
        logic                        clear;
        logic [GAIN_BITS-1:0]        gain;
    } t_prod_item;

    // after truncation and saturation
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] q;
        logic                          clipped;
        logic [METER_BITS-1:0]         mag;
        logic                          last;
        logic                          clear;
        logic [GAIN_BITS-1:0]          gain;
    } t_sat_item;

endpackage

>>> hdl/sgcpm_gain.sv
// Gain smoothing stage: holds the current gain and steps it toward the target
// on the first word of a buffer. Depends on sgcpm_pkg.
module sgcpm_gain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  sgcpm_pkg::t_in_word           i_item,
    input  logic [sgcpm_pkg::COEFF_BITS-1:0] i_coeff,
    input  logic [sgcpm_pkg::THR_BITS-1:0]   i_thr,
    output logic                          o_valid,
    output sgcpm_pkg::t_gain_item         o_item
);
    import sgcpm_pkg::*;

    localparam int MW = GAIN_BITS + COEFF_BITS + 2;

    logic [GAIN_BITS-1:0]     r_gain, n_gain;
    logic                     r_valid;
    t_gain_item               r_item;

    logic [GAIN_BITS-1:0]     w_tgt;
    logic signed [GAIN_BITS:0] w_d, w_d2, w_step, w_stepped;
    logic [GAIN_BITS-1:0]     w_abs_d, w_abs_d2, w_thr, w_lo, w_hi;
    logic signed [MW-1:0]     w_prod, w_adj;
    logic                     w_do;

    assign w_tgt = i_item.target_gain;
    assign w_thr = GAIN_BITS'(i_thr);

    assign w_d     = $signed({1'b0, w_tgt}) - $signed({1'b0, r_gain});
    assign w_abs_d = w_d[GAIN_BITS] ? GAIN_BITS'(-w_d) : w_d[GAIN_BITS-1:0];

    // step = d * coeff / 2^16, truncated toward zero
    assign w_prod = w_d * $signed({1'b0, i_coeff});
    assign w_adj  = w_prod + (w_prod[MW-1] ? {{(MW-COEFF_BITS){1'b0}}, {COEFF_BITS{1'b1}}}
                                           : {MW{1'b0}});
    assign w_step = w_adj[COEFF_BITS +: GAIN_BITS+1];

    assign w_stepped = $signed({1'b0, r_gain}) + w_step;
    assign w_d2      = $signed({1'b0, w_tgt}) - w_stepped;
    assign w_abs_d2  = w_d2[GAIN_BITS] ? GAIN_BITS'(-w_d2) : w_d2[GAIN_BITS-1:0];

    assign w_do = i_adv && i_valid && i_item.first_of_buffer;

    always_comb begin
        n_gain = r_gain;
        if (w_do && (w_abs_d > w_thr)) begin
            n_gain = (w_abs_d2 < w_thr) ? w_tgt : w_stepped[GAIN_BITS-1:0];
        end
    end

    assign w_lo = (w_tgt < r_gain) ? w_tgt : r_gain;
    assign w_hi = (w_tgt < r_gain) ? r_gain : w_tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_UNITY;
            r_valid <= 1'b0;
        end else begin
            r_gain <= n_gain;
            if (i_adv) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item.sample <= i_item.sample;
            r_item.last   <= i_item.last_of_buffer;
            r_item.clear  <= i_item.clear_clip;
            r_item.gain   <= n_gain;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

`ifndef SYNTH
    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do |=> (r_gain >= $past(w_lo)) && (r_gain <= $past(w_hi)))
        else $error("gain left the span between old gain and target");
    a_gain_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_do |=> $stable(r_gain))
        else $error("gain moved without a buffer start");
`endif

endmodule

>>> hdl/sgcpm_mul.sv
// Multiply stage and truncate/saturate stage: sample times gain in unsigned Q11.20,
// clip detection on the exact product. Depends on sgcpm_pkg.
module sgcpm_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  sgcpm_pkg::t_gain_item i_item,
    output logic                  o_valid,
    output sgcpm_pkg::t_sat_item  o_item
);
    import sgcpm_pkg::*;

    localparam int QW = PROD_BITS - GAIN_FRAC_BITS;
    localparam logic signed [PROD_BITS-1:0] P_HI  = PROD_BITS'(CLIP_HI);
    localparam logic signed [PROD_BITS-1:0] P_LO  = PROD_BITS'(CLIP_LO);
    localparam logic signed [QW-1:0]        Q_MAX = QW'(SAT_MAX);
    localparam logic signed [QW-1:0]        Q_MIN = QW'(SAT_MIN);

    logic                        r_p_valid, r_s_valid;
    t_prod_item                  r_p;
    t_sat_item                   r_s;

    logic signed [PROD_BITS-1:0] w_prod, w_adj;
    logic signed [QW-1:0]        w_qfull;
    logic signed [SAMPLE_BITS-1:0] w_q;
    logic [METER_BITS-1:0]       w_mag;
    logic                        w_clip;

    assign w_prod = $signed(i_item.sample) * $signed({1'b0, i_item.gain});

    // truncate toward zero: bias negative products before the shift
    assign w_adj   = r_p.prod + (r_p.prod[PROD_BITS-1]
                     ? {{QW{1'b0}}, {GAIN_FRAC_BITS{1'b1}}} : {PROD_BITS{1'b0}});
    assign w_qfull = w_adj[PROD_BITS-1:GAIN_FRAC_BITS];
    assign w_clip  = (r_p.prod >= P_HI) || (r_p.prod <= P_LO);

    always_comb begin
        if (w_qfull > Q_MAX) begin
            w_q = Q_MAX[SAMPLE_BITS-1:0];
        end else if (w_qfull < Q_MIN) begin
            w_q = Q_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_q = w_qfull[SAMPLE_BITS-1:0];
        end
    end

    // full-scale negative gives 2^23, which still fits unsigned
    assign w_mag = w_q[SAMPLE_BITS-1] ? (~w_q + 1'b1) : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (i_adv) begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p.prod    <= w_prod;
            r_p.last    <= i_item.last;
            r_p.clear   <= i_item.clear;
            r_p.gain    <= i_item.gain;
            r_s.q       <= w_q;
            r_s.clipped <= w_clip;
            r_s.mag     <= w_mag;
            r_s.last    <= r_p.last;
            r_s.clear   <= r_p.clear;
            r_s.gain    <= r_p.gain;
        end
    end

    assign o_valid = r_s_valid;
    assign o_item  = r_s;

endmodule

>>> hdl/sgcpm_meter.sv
// Peak meter, sticky clip flag and result register.
// Depends on sgcpm_pkg.
module sgcpm_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  sgcpm_pkg::t_sat_item          i_item,
    input  logic [sgcpm_pkg::COEFF_BITS-1:0] i_decay,
    output logic                          o_valid,
    output sgcpm_pkg::t_out_word          o_word
);
    import sgcpm_pkg::*;

    localparam int DW = METER_BITS + COEFF_BITS;

    logic [METER_BITS-1:0] r_peak, n_peak, r_meter, n_meter;
    logic                  r_clip, n_clip;
    logic                  r_valid;
    t_out_word             r_word;

    logic [DW-1:0]         w_decay_full;
    logic [METER_BITS-1:0] w_decayed, w_peak_upd;
    logic                  w_take;

    assign w_take       = i_adv && i_valid;
    assign w_decay_full = r_meter * i_decay;
    assign w_decayed    = w_decay_full[DW-1:COEFF_BITS];
    assign w_peak_upd   = (i_item.mag > r_peak) ? i_item.mag : r_peak;

    always_comb begin
        n_peak  = r_peak;
        n_meter = r_meter;
        n_clip  = r_clip;
        if (w_take) begin
            n_clip = (r_clip && !i_item.clear) || i_item.clipped;
            n_peak = w_peak_upd;
            if (i_item.last) begin
                n_meter = (w_peak_upd > w_decayed) ? w_peak_upd : w_decayed;
                n_peak  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_meter <= '0;
            r_clip  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_peak  <= n_peak;
            r_meter <= n_meter;
            r_clip  <= n_clip;
            if (i_adv) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word.out_sample     <= i_item.q;
            r_word.sample_clipped <= i_item.clipped;
            r_word.clip_seen      <= n_clip;
            r_word.meter_level    <= n_meter;
            r_word.gain_now       <= i_item.gain;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

`ifndef SYNTH
    a_meter_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_take && i_item.last) |=> $stable(r_meter))
        else $error("meter changed away from a buffer end");
    a_clip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_item.clipped) |=> r_clip)
        else $error("clipped word did not set the clip flag");
`endif

endmodule

>>> hdl/smoothed_gain_clip_peak_meter.sv
// Top level: configuration registers, input skid register and the pipeline.
// Depends on sgcpm_pkg, sgcpm_gain, sgcpm_mul, sgcpm_meter.
//
//   channel  direction  handshake                  payload
//   input    in         i_in_valid / o_in_stall    i_in_word  (t_in_word)
//   output   out        o_out_valid / i_out_stall  o_out_word (t_out_word)
//   config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One word per cycle sustained unless the output stalls. The gain feedback
// (one 32x17 multiply) and the meter decay (24x16) are combinational. Reset
// restores unity gain, zero meter and peak, clear clip flag and default
// registers. A stalled result freezes the whole pipeline; one further
// input word is caught in the skid register.
module smoothed_gain_clip_peak_meter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sgcpm_pkg::t_in_word              i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sgcpm_pkg::t_out_word             o_out_word,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sgcpm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [sgcpm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [sgcpm_pkg::DATA_BITS-1:0]  prdata,
    output logic                             pready
);
    import sgcpm_pkg::*;

    logic [COEFF_BITS-1:0] r_coeff, r_decay;
    logic [THR_BITS-1:0]   r_thr;
    t_reg_idx              w_idx;

    logic                  r_skid_full, r_a_valid;
    t_in_word              r_skid, r_a_word;
    logic                  w_adv, w_accept;

    logic                  w_g_valid, w_s_valid;
    t_gain_item            w_g_item;
    t_sat_item             w_s_item;

    // ---- configuration port
    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= COEFF_RST;
            r_thr   <= THR_RST;
            r_decay <= DECAY_RST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_COEFF: r_coeff <= pwdata[COEFF_BITS-1:0];
                REG_THR:   r_thr   <= pwdata[THR_BITS-1:0];
                REG_DECAY: r_decay <= pwdata[COEFF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_COEFF: prdata = DATA_BITS'(r_coeff);
            REG_THR:   prdata = DATA_BITS'(r_thr);
            REG_DECAY: prdata = DATA_BITS'(r_decay);
            default:   prdata = '0;
        endcase
    end

    // ---- input side: skid register then input register
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = r_skid_full;
    assign w_accept   = i_in_valid && !r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
            r_a_valid   <= 1'b0;
        end else if (w_adv) begin
            r_skid_full <= 1'b0;
            r_a_valid   <= r_skid_full || w_accept;
        end else if (w_accept) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_word <= r_skid_full ? r_skid : i_in_word;
        end else if (w_accept) begin
            r_skid <= i_in_word;
        end
    end

    // ---- pipeline
    sgcpm_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_a_valid),
        .i_item  (r_a_word),
        .i_coeff (r_coeff),
        .i_thr   (r_thr),
        .o_valid (w_g_valid),
        .o_item  (w_g_item)
    );

    sgcpm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_g_valid),
        .i_item  (w_g_item),
        .o_valid (w_s_valid),
        .o_item  (w_s_item)
    );

    sgcpm_meter u_meter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_s_valid),
        .i_item  (w_s_item),
        .i_decay (r_decay),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

`ifndef SYNTH
    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && !w_adv) |=> r_skid_full)
        else $error("skid word dropped while the pipeline was frozen");
    a_frozen_input_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_a_valid))
        else $error("input register changed while the pipeline was frozen");
`endif

endmodule
